@@ hw/rtl/chpe_pkg.sv @@
`default_nettype none

package chpe_pkg;

  // curve parameter and its powers, all unsigned Q.16
  localparam int POS_W  = 17;
  localparam int FRAC_W = 16;
  localparam int TT_W   = 2 * POS_W;
  localparam int T2_W   = TT_W - FRAC_W;
  localparam int T2T_W  = T2_W + POS_W;
  localparam int T3_W   = T2T_W - FRAC_W;

  // signed basis weight width, covers extrapolation up to t just below 2.0
  localparam int WGT_W = 22;

  localparam int ROUND_HALF = 32768;
  localparam int ONE_Q16    = 65536;
  localparam logic signed [WGT_W-1:0] ONE_W = WGT_W'(ONE_Q16);

  // configuration register map
  localparam int NUM_REGS  = 8;
  localparam int REG_SEL_W = 3;
  localparam int IDX_W     = 4;

  localparam int REG_START_X         = 0;
  localparam int REG_START_Y         = 1;
  localparam int REG_END_X           = 2;
  localparam int REG_END_Y           = 3;
  localparam int REG_START_TANGENT_X = 4;
  localparam int REG_START_TANGENT_Y = 5;
  localparam int REG_END_TANGENT_X   = 6;
  localparam int REG_END_TANGENT_Y   = 7;

  // x and y sit next to each other, so one axis offset selects the pair
  localparam int AXIS_X = 0;
  localparam int AXIS_Y = 1;

  typedef struct packed {
    logic signed [WGT_W-1:0] h00;
    logic signed [WGT_W-1:0] h01;
    logic signed [WGT_W-1:0] h10;
    logic signed [WGT_W-1:0] h11;
  } weights_t;

endpackage

`default_nettype wire

@@ hw/rtl/chpe_ifs.sv @@
`default_nettype none

interface chpe_in_if;
  logic                        valid;
  logic                        ready;
  logic [chpe_pkg::POS_W-1:0]  curve_position;

  modport source (output valid, output curve_position, input ready);
  modport sink   (input valid, input curve_position, output ready);
endinterface

interface chpe_out_if #(
  parameter int COORD_WIDTH = 16
);
  logic                           valid;
  logic                           ready;
  logic signed [COORD_WIDTH-1:0]  point_x;
  logic signed [COORD_WIDTH-1:0]  point_y;
  logic                           clipped;

  modport source (output valid, output point_x, output point_y, output clipped, input ready);
  modport sink   (input valid, input point_x, input point_y, input clipped, output ready);
endinterface

interface chpe_cfg_if #(
  parameter int COORD_WIDTH = 16
);
  logic                         valid;
  logic                         ready;
  logic [chpe_pkg::IDX_W-1:0]   index;
  logic [COORD_WIDTH-1:0]       data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

@@ hw/rtl/cubic_hermite_point_evaluator.sv @@
`default_nettype none

// channel   dir  transaction payload
// in_ch     in   curve_position (17 bit, unsigned Q1.16, 65536 = 1.0)
// out_ch    out  point_x, point_y (COORD_WIDTH bit signed), clipped
// cfg_ch    in   index (4 bit), data (COORD_WIDTH bit), indexes 0..7 only
//
// one point per cycle sustained while out_ch does not stall
// the pipeline is seven register stages: t^2, t^3, basis weights, the eight
// coefficient products, pair sums, total, round and saturate
// rst_n is synchronous; it empties the pipeline and clears all coefficients
// a stall on out_ch holds every full stage; empty stages in front still fill
// cfg_ch is always ready; the user must write it only while the pipeline is empty, the block does not enforce this

module cubic_hermite_point_evaluator #(
  parameter int COORD_WIDTH = 16
) (
  input  wire logic  clk,
  input  wire logic  rst_n,
  chpe_in_if.sink    in_ch,
  chpe_out_if.source out_ch,
  chpe_cfg_if.sink   cfg_ch
);

  logic [chpe_pkg::NUM_REGS-1:0][COORD_WIDTH-1:0] coef;
  chpe_pkg::weights_t wgt;
  logic               wgt_valid;
  logic               wgt_ready;

  chpe_regfile #(
    .COORD_WIDTH (COORD_WIDTH)
  ) u_regfile (
    .clk   (clk),
    .rst_n (rst_n),
    .cfg   (cfg_ch),
    .coef  (coef)
  );

  chpe_basis u_basis (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .in_pos    (in_ch.curve_position),
    .out_valid (wgt_valid),
    .out_ready (wgt_ready),
    .out_wgt   (wgt)
  );

  chpe_blend #(
    .COORD_WIDTH (COORD_WIDTH)
  ) u_blend (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (wgt_valid),
    .in_ready  (wgt_ready),
    .in_wgt    (wgt),
    .coef      (coef),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .point_x   (out_ch.point_x),
    .point_y   (out_ch.point_y),
    .clipped   (out_ch.clipped)
  );

  // input back-pressure only comes from a full pipeline behind a stalled output
  assert property (@(posedge clk) disable iff (!rst_n)
    !in_ch.ready |-> (out_ch.valid && !out_ch.ready && wgt_valid && !wgt_ready))
    else $error("input stalled with room left in the pipeline");

endmodule

`default_nettype wire

@@ hw/rtl/chpe_regfile.sv @@
`default_nettype none

module chpe_regfile #(
  parameter int COORD_WIDTH = 16
) (
  input  wire logic clk,
  input  wire logic rst_n,
  chpe_cfg_if.sink  cfg,
  output logic [chpe_pkg::NUM_REGS-1:0][COORD_WIDTH-1:0] coef
);

  logic [chpe_pkg::NUM_REGS-1:0][COORD_WIDTH-1:0] coef_r;
  logic                                           wr_en;

  always_comb begin
    cfg.ready = 1'b1;
    // indexes past the register map are dropped
    wr_en = cfg.valid && (cfg.index < chpe_pkg::IDX_W'(chpe_pkg::NUM_REGS));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      coef_r <= '0;
    end else if (wr_en) begin
      coef_r[cfg.index[chpe_pkg::REG_SEL_W-1:0]] <= cfg.data;
    end
  end

  assign coef = coef_r;

endmodule

`default_nettype wire

@@ hw/rtl/chpe_basis.sv @@
`default_nettype none

module chpe_basis (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        in_valid,
  output logic                             in_ready,
  input  wire logic [chpe_pkg::POS_W-1:0]  in_pos,
  output logic                             out_valid,
  input  wire logic                        out_ready,
  output chpe_pkg::weights_t               out_wgt
);

  localparam int NSTG = 3;

  logic [NSTG-1:0] vld_r, vld_nxt, rdy;

  // stage 1: t and t*t
  logic [chpe_pkg::POS_W-1:0]  s1_t_r;
  logic [chpe_pkg::TT_W-1:0]   s1_tt_r;
  // stage 2: t, t2 and t2*t
  logic [chpe_pkg::POS_W-1:0]  s2_t_r;
  logic [chpe_pkg::T2_W-1:0]   s2_t2_r;
  logic [chpe_pkg::T2T_W-1:0]  s2_t2t_r;
  // stage 3: weights
  chpe_pkg::weights_t          s3_wgt_r;

  logic [chpe_pkg::TT_W-1:0]   tt;
  logic [chpe_pkg::TT_W-1:0]   t2_sum;
  logic [chpe_pkg::T2_W-1:0]   t2;
  logic [chpe_pkg::T2T_W-1:0]  t2t;
  logic [chpe_pkg::T2T_W-1:0]  t3_sum;
  logic [chpe_pkg::T3_W-1:0]   t3;
  logic signed [chpe_pkg::WGT_W-1:0] w_t, w_t2, w_t3, w_t2x2, w_t2x3, w_t3x2;
  chpe_pkg::weights_t          wgt;

  // a stage takes new data when it is empty or its successor moves on
  always_comb begin
    rdy[NSTG-1] = !vld_r[NSTG-1] || out_ready;
    for (int i = NSTG-2; i >= 0; i--) begin
      rdy[i] = !vld_r[i] || rdy[i+1];
    end
    vld_nxt[0] = rdy[0] ? in_valid : vld_r[0];
    for (int i = 1; i < NSTG; i++) begin
      vld_nxt[i] = rdy[i] ? vld_r[i-1] : vld_r[i];
    end
  end

  always_comb begin
    tt     = chpe_pkg::TT_W'(in_pos) * chpe_pkg::TT_W'(in_pos);
    // round half up back to Q.16
    t2_sum = s1_tt_r + chpe_pkg::TT_W'(chpe_pkg::ROUND_HALF);
    t2     = t2_sum[chpe_pkg::TT_W-1:chpe_pkg::FRAC_W];
    t2t    = chpe_pkg::T2T_W'(t2) * chpe_pkg::T2T_W'(s1_t_r);
    t3_sum = s2_t2t_r + chpe_pkg::T2T_W'(chpe_pkg::ROUND_HALF);
    t3     = t3_sum[chpe_pkg::T2T_W-1:chpe_pkg::FRAC_W];

    w_t    = $signed(chpe_pkg::WGT_W'(s2_t_r));
    w_t2   = $signed(chpe_pkg::WGT_W'(s2_t2_r));
    w_t3   = $signed(chpe_pkg::WGT_W'(t3));
    w_t2x2 = w_t2 <<< 1;
    w_t2x3 = w_t2 + w_t2x2;
    w_t3x2 = w_t3 <<< 1;

    wgt.h00 = w_t3x2 - w_t2x3 + chpe_pkg::ONE_W;
    wgt.h01 = w_t2x3 - w_t3x2;
    wgt.h10 = w_t3 - w_t2x2 + w_t;
    wgt.h11 = w_t3 - w_t2;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy[0] && in_valid) begin
      s1_t_r  <= in_pos;
      s1_tt_r <= tt;
    end
    if (rdy[1] && vld_r[0]) begin
      s2_t_r   <= s1_t_r;
      s2_t2_r  <= t2;
      s2_t2t_r <= t2t;
    end
    if (rdy[2] && vld_r[1]) begin
      s3_wgt_r <= wgt;
    end
  end

  assign in_ready  = rdy[0];
  assign out_valid = vld_r[NSTG-1];
  assign out_wgt   = s3_wgt_r;

  // the end-point weights always add up to one
  assert property (@(posedge clk) disable iff (!rst_n)
    vld_r[NSTG-1] |-> ((s3_wgt_r.h00 + s3_wgt_r.h01) == chpe_pkg::ONE_W))
    else $error("end-point weights do not sum to one");

endmodule

`default_nettype wire

@@ hw/rtl/chpe_blend.sv @@
`default_nettype none

module chpe_blend #(
  parameter int COORD_WIDTH = 16
) (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       in_valid,
  output logic                            in_ready,
  input  wire chpe_pkg::weights_t         in_wgt,
  input  wire logic [chpe_pkg::NUM_REGS-1:0][COORD_WIDTH-1:0] coef,
  output logic                            out_valid,
  input  wire logic                       out_ready,
  output logic signed [COORD_WIDTH-1:0]   point_x,
  output logic signed [COORD_WIDTH-1:0]   point_y,
  output logic                            clipped
);

  localparam int NSTG   = 4;
  localparam int NAXIS  = 2;
  localparam int NTERM  = 4;
  localparam int PROD_W = COORD_WIDTH + chpe_pkg::WGT_W;
  localparam int PAIR_W = PROD_W + 1;
  localparam int SUM_W  = PROD_W + 2;
  localparam int RND_W  = SUM_W - chpe_pkg::FRAC_W;
  localparam logic signed [RND_W-1:0] SAT_HI =
    {{(RND_W-COORD_WIDTH+1){1'b0}}, {(COORD_WIDTH-1){1'b1}}};
  localparam logic signed [RND_W-1:0] SAT_LO = ~SAT_HI;
  localparam logic signed [COORD_WIDTH-1:0] OUT_HI = SAT_HI[COORD_WIDTH-1:0];
  localparam logic signed [COORD_WIDTH-1:0] OUT_LO = SAT_LO[COORD_WIDTH-1:0];

  logic [NSTG-1:0] vld_r, vld_nxt, rdy;

  logic signed [PROD_W-1:0]      s4_prod_r [NAXIS][NTERM];
  logic signed [PAIR_W-1:0]      s5_pair_r [NAXIS][2];
  logic signed [SUM_W-1:0]       s6_sum_r  [NAXIS];
  logic signed [COORD_WIDTH-1:0] point_x_r, point_y_r;
  logic                          clipped_r;

  logic signed [PROD_W-1:0]      prod      [NAXIS][NTERM];
  logic signed [PAIR_W-1:0]      pair      [NAXIS][2];
  logic signed [SUM_W-1:0]       total     [NAXIS];
  logic signed [COORD_WIDTH-1:0] coord     [NAXIS];
  logic [NAXIS-1:0]              sat;
  logic signed [PROD_W-1:0]      wgt_ext   [NTERM];
  logic signed [PROD_W-1:0]      cw;
  logic signed [SUM_W-1:0]       biased    [NAXIS];
  logic signed [RND_W-1:0]       rnd       [NAXIS];

  always_comb begin
    rdy[NSTG-1] = !vld_r[NSTG-1] || out_ready;
    for (int i = NSTG-2; i >= 0; i--) begin
      rdy[i] = !vld_r[i] || rdy[i+1];
    end
    vld_nxt[0] = rdy[0] ? in_valid : vld_r[0];
    for (int i = 1; i < NSTG; i++) begin
      vld_nxt[i] = rdy[i] ? vld_r[i-1] : vld_r[i];
    end
  end

  // term k of an axis uses register pair k: start, end, start tangent, end tangent
  always_comb begin
    wgt_ext[0] = PROD_W'(in_wgt.h00);
    wgt_ext[1] = PROD_W'(in_wgt.h01);
    wgt_ext[2] = PROD_W'(in_wgt.h10);
    wgt_ext[3] = PROD_W'(in_wgt.h11);
    cw = '0;
    for (int a = 0; a < NAXIS; a++) begin
      for (int k = 0; k < NTERM; k++) begin
        cw         = PROD_W'($signed(coef[chpe_pkg::REG_START_X + 2*k + a]));
        prod[a][k] = cw * wgt_ext[k];
      end
    end
  end

  always_comb begin
    for (int a = 0; a < NAXIS; a++) begin
      pair[a][0] = PAIR_W'(s4_prod_r[a][0]) + PAIR_W'(s4_prod_r[a][1]);
      pair[a][1] = PAIR_W'(s4_prod_r[a][2]) + PAIR_W'(s4_prod_r[a][3]);
      total[a]   = SUM_W'(s5_pair_r[a][0]) + SUM_W'(s5_pair_r[a][1]);
      // round half up, floor shift is exact for negative sums too
      biased[a]  = s6_sum_r[a] + SUM_W'(chpe_pkg::ROUND_HALF);
      rnd[a]     = biased[a][SUM_W-1:chpe_pkg::FRAC_W];
      if (rnd[a] > SAT_HI) begin
        coord[a] = OUT_HI;
        sat[a]   = 1'b1;
      end else if (rnd[a] < SAT_LO) begin
        coord[a] = OUT_LO;
        sat[a]   = 1'b1;
      end else begin
        coord[a] = rnd[a][COORD_WIDTH-1:0];
        sat[a]   = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy[0] && in_valid) begin
      s4_prod_r <= prod;
    end
    if (rdy[1] && vld_r[0]) begin
      s5_pair_r <= pair;
    end
    if (rdy[2] && vld_r[1]) begin
      s6_sum_r <= total;
    end
    if (rdy[3] && vld_r[2]) begin
      point_x_r <= coord[chpe_pkg::AXIS_X];
      point_y_r <= coord[chpe_pkg::AXIS_Y];
      clipped_r <= |sat;
    end
  end

  assign in_ready  = rdy[0];
  assign out_valid = vld_r[NSTG-1];
  assign point_x   = point_x_r;
  assign point_y   = point_y_r;
  assign clipped   = clipped_r;

  // a clipped point has at least one coordinate pinned to a rail
  assert property (@(posedge clk) disable iff (!rst_n)
    (vld_r[NSTG-1] && clipped_r) |->
      (point_x_r == OUT_HI || point_x_r == OUT_LO ||
       point_y_r == OUT_HI || point_y_r == OUT_LO))
    else $error("clipped point with no saturated coordinate");

  // a clipped point cannot come out of a sum that stayed inside the rails
  assert property (@(posedge clk) disable iff (!rst_n)
    (rdy[3] && vld_r[2] && !(|sat)) |=> !clipped_r)
    else $error("clip flag set without saturation");

endmodule

`default_nettype wire
